// ===== rtl/core/laser_monitor_scan_supervisor_core_assert.svh =====
// Assertion macros for the laser monitor scan supervisor core.
// Included by the top level; clock and reset are taken from the including scope.
`ifndef LASER_MONITOR_SCAN_SUPERVISOR_CORE_ASSERT_SVH
`define LASER_MONITOR_SCAN_SUPERVISOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define LMSS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked during reset as well
`define LMSS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LMSS_ASSERT(label, prop, msg)
`define LMSS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/core/lmss_pkg.sv =====
// Shared types and constants of the laser monitor scan supervisor.
// No dependencies; imported by every module of the core.
package lmss_pkg;

   localparam int SampleW      = 12;
   localparam int RankCntW     = 3;
   localparam int RankW        = 4;
   localparam int CsrIdxW      = 3;
   localparam int DefWindowLen = 16;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_CAPTURE_THRESHOLD   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_OVERCURRENT_LIMIT   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_TEMP_MATCH_WINDOW   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_TEMP_SETPOINT_START = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_LASER_DRIVE_START   = 3'd4;

   // configuration reset values
   localparam logic [SampleW-1:0] RST_CAPTURE_THRESHOLD   = 12'd2048;
   localparam logic [SampleW-1:0] RST_OVERCURRENT_LIMIT   = 12'd4095;
   localparam logic [SampleW-1:0] RST_TEMP_MATCH_WINDOW   = 12'd16;
   localparam logic [SampleW-1:0] RST_TEMP_SETPOINT_START = 12'd2048;
   localparam logic [SampleW-1:0] RST_LASER_DRIVE_START   = 12'd0;

   // rank counter codes (rank number minus one)
   localparam logic [RankCntW-1:0] RANK_INNER_PD  = 3'd2;
   localparam logic [RankCntW-1:0] RANK_EXT_PD    = 3'd3;
   localparam logic [RankCntW-1:0] RANK_REAL_TEMP = 3'd4;
   localparam logic [RankCntW-1:0] RANK_SET_TEMP  = 3'd5;
   localparam logic [RankCntW-1:0] RANK_CURRENT   = 3'd7;

   // one item presented to the supervisor when it is processed
   typedef struct packed {
      logic               fire;
      logic [SampleW-1:0] sample;
      logic               stab_on;
      logic               power_hold_on;
      logic               in_stab_wait;
      logic               scan_init_settled;
      logic               set_scan_init;
      logic               clear_flags;
   } step_type;

   typedef struct packed {
      logic [SampleW-1:0] capture_threshold;
      logic [SampleW-1:0] overcurrent_limit;
      logic [SampleW-1:0] temp_match_window;
   } cfg_type;

   // start-register write that also loads the working register
   typedef struct packed {
      logic               load_setpoint;
      logic               load_drive;
      logic [SampleW-1:0] data;
   } preload_type;

   typedef struct packed {
      logic [RankW-1:0]   sample_rank;
      logic [SampleW-1:0] temp_setpoint;
      logic               temp_setpoint_changed;
      logic [SampleW-1:0] laser_drive;
      logic               capture_flag;
      logic               temp_equal_flag;
      logic               scan_init_flag;
      logic               overcurrent_flag;
      logic               laser_off_request;
   } result_type;

endpackage

// ===== rtl/core/laser_monitor_scan_supervisor_core.sv =====
// Top level of the laser monitor scan supervisor: handshake, config, result register.
// Depends on lmss_pkg, lmss_window, lmss_supervise and the assertion header.
//
// One conversion is taken per transfer and one result comes back for each, in
// order. The core sustains one transfer per clock cycle while the result side
// accepts: a conversion is scaled by the window length on its way into the
// input register and is processed from there into the result register, which
// offers the result; a result not taken stalls both registers. The window
// store is a RAM read one entry ahead of its pointer; it needs no clearing pass
// after reset, because entries are counted as zero until the pointer has wrapped
// once. Configuration writes take effect at once; a write to a start register
// also loads the working setpoint or drive. Ranks rotate 1 to 8 starting at
// rank 1 after reset.
module laser_monitor_scan_supervisor_core
   import lmss_pkg::*;
#(
   parameter int WINDOW_LEN = DefWindowLen
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [SampleW-1:0] req_sample,
   input  logic               req_stab_on,
   input  logic               req_power_hold_on,
   input  logic               req_in_stab_wait,
   input  logic               req_scan_init_settled,
   input  logic               req_set_scan_init,
   input  logic               req_clear_flags,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [RankW-1:0]   rsp_sample_rank,
   output logic [SampleW-1:0] rsp_window_average,
   output logic [SampleW-1:0] rsp_temp_setpoint,
   output logic               rsp_temp_setpoint_changed,
   output logic [SampleW-1:0] rsp_laser_drive,
   output logic               rsp_capture_flag,
   output logic               rsp_temp_equal_flag,
   output logic               rsp_scan_init_flag,
   output logic               rsp_overcurrent_flag,
   output logic               rsp_laser_off_request,
   input  logic               csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [SampleW-1:0] csr_write_data
);

   // exact divide by the window length: x / L == (x * ceil(2^S / L)) >> S
   localparam int WinShift = SampleW + $clog2(WINDOW_LEN);
   localparam longint unsigned WinRecip =
      ((longint'(1) << WinShift) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
   localparam int RecipW = SampleW + 2;
   localparam int ProdW  = SampleW + RecipW;

   // configuration
   logic [SampleW-1:0] thr_ff, limit_ff, match_ff;
   cfg_type            cfg;
   preload_type        preload;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= RST_CAPTURE_THRESHOLD;
         limit_ff <= RST_OVERCURRENT_LIMIT;
         match_ff <= RST_TEMP_MATCH_WINDOW;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAPTURE_THRESHOLD: thr_ff   <= csr_write_data;
            CSR_OVERCURRENT_LIMIT: limit_ff <= csr_write_data;
            CSR_TEMP_MATCH_WINDOW: match_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.capture_threshold = thr_ff;
      cfg.overcurrent_limit = limit_ff;
      cfg.temp_match_window = match_ff;
      preload.load_setpoint = csr_write_enable && (csr_index == CSR_TEMP_SETPOINT_START);
      preload.load_drive    = csr_write_enable && (csr_index == CSR_LASER_DRIVE_START);
      preload.data          = csr_write_data;
   end

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               advance;
   logic [ProdW-1:0]   win_prod;
   logic [ProdW-1:0]   win_quot;
   logic [SampleW-1:0] entry_ff;
   step_type           step_ff;
   step_type           step;
   logic               rsp_valid_ff, rsp_valid_in;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   assign win_prod = ProdW'(req_sample) * ProdW'(RecipW'(WinRecip));
   assign win_quot = win_prod >> WinShift;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         entry_ff                  <= win_quot[SampleW-1:0];
         step_ff.fire              <= 1'b1;
         step_ff.sample            <= req_sample;
         step_ff.stab_on           <= req_stab_on;
         step_ff.power_hold_on     <= req_power_hold_on;
         step_ff.in_stab_wait      <= req_in_stab_wait;
         step_ff.scan_init_settled <= req_scan_init_settled;
         step_ff.set_scan_init     <= req_set_scan_init;
         step_ff.clear_flags       <= req_clear_flags;
      end
   end

   always_comb begin
      step      = step_ff;
      step.fire = advance;
   end

   // processing
   logic               win_update;
   logic [SampleW-1:0] sum_next;
   result_type         result;

   lmss_supervise u_supervise (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cfg        (cfg),
      .preload    (preload),
      .win_update (win_update),
      .result     (result)
   );

   lmss_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .update   (win_update),
      .entry    (entry_ff),
      .sum_next (sum_next)
   );

   // result register
   result_type         result_ff;
   logic [SampleW-1:0] average_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff  <= result;
         average_ff <= sum_next;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_sample_rank           = result_ff.sample_rank;
   assign rsp_window_average        = average_ff;
   assign rsp_temp_setpoint         = result_ff.temp_setpoint;
   assign rsp_temp_setpoint_changed = result_ff.temp_setpoint_changed;
   assign rsp_laser_drive           = result_ff.laser_drive;
   assign rsp_capture_flag          = result_ff.capture_flag;
   assign rsp_temp_equal_flag       = result_ff.temp_equal_flag;
   assign rsp_scan_init_flag        = result_ff.scan_init_flag;
   assign rsp_overcurrent_flag      = result_ff.overcurrent_flag;
   assign rsp_laser_off_request     = result_ff.laser_off_request;

   // checks
`include "laser_monitor_scan_supervisor_core_assert.svh"

   `LMSS_ASSERT_ALWAYS(a_reset_empties, reset |=> !in_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")
   `LMSS_ASSERT(a_held_item_kept, in_valid_ff && !advance |=> in_valid_ff, "held input item lost")
   `LMSS_ASSERT(a_off_sets_flag, rsp_valid && rsp_laser_off_request |-> rsp_overcurrent_flag, "laser off without overcurrent flag")
   `LMSS_ASSERT(a_setpoint_rank, rsp_valid && rsp_temp_setpoint_changed |-> rsp_sample_rank == RankW'(RANK_EXT_PD) + 1'b1, "setpoint moved outside external photodiode rank")

endmodule

// ===== rtl/core/lmss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on lmss_pkg for the default width and depth.
module lmss_ram
   import lmss_pkg::*;
#(
   parameter int WIDTH = SampleW,
   parameter int DEPTH = DefWindowLen
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lmss_window.sv =====
// Boxcar window average: entry store in RAM, running sum and write pointer.
// Depends on lmss_pkg and lmss_ram.
module lmss_window
   import lmss_pkg::*;
#(
   parameter int WINDOW_LEN = DefWindowLen
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               update,
   input  logic [SampleW-1:0] entry,
   output logic [SampleW-1:0] sum_next
);

   localparam int PtrW = $clog2(WINDOW_LEN);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_LEN - 1);

   logic [PtrW-1:0]    ptr_ff, ptr_in;
   logic               wrapped_ff, wrapped_in;
   logic [SampleW-1:0] sum_ff, sum_in;
   logic [SampleW-1:0] rd_data;
   logic [SampleW-1:0] old_entry;

   // entries are written in pointer order, so before the first wrap the slot
   // at the pointer has never been written and reads as zero
   assign old_entry = wrapped_ff ? rd_data : '0;

   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      sum_in     = sum_ff;
      if (update) begin
         sum_in = sum_ff - old_entry + entry;
         if (ptr_ff == PtrLast) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         wrapped_ff <= wrapped_in;
         sum_ff     <= sum_in;
      end
   end

   // read ahead at the next pointer so the old entry is ready when needed
   lmss_ram #(
      .WIDTH (SampleW),
      .DEPTH (WINDOW_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (update),
      .wr_addr (ptr_ff),
      .wr_data (entry),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   assign sum_next = sum_in;

endmodule

// ===== rtl/core/lmss_supervise.sv =====
// Rank sequencing, laser drive hold, setpoint stepping and status flags.
// Depends on lmss_pkg.
module lmss_supervise
   import lmss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  step_type    step,
   input  cfg_type     cfg,
   input  preload_type preload,
   output logic        win_update,
   output result_type  result
);

   logic [RankCntW-1:0] rank_ff, rank_in;
   logic [SampleW-1:0]  setpoint_ff, setpoint_in;
   logic [SampleW-1:0]  drive_ff, drive_in;
   logic [SampleW-1:0]  hold_ref_ff, hold_ref_in;
   logic                hold_prev_ff, hold_prev_in;
   logic [SampleW-1:0]  current_ff, current_in;
   logic [SampleW-1:0]  real_temp_ff, real_temp_in;
   logic                cap_ff, cap_in;
   logic                teq_ff, teq_in;
   logic                scan_ff, scan_in;
   logic                ovc_ff, ovc_in;
   logic                off_req;
   logic [SampleW-1:0]  hold_target;
   logic [SampleW-1:0]  temp_diff;

   function automatic logic [SampleW-1:0] step_toward(
      input logic [SampleW-1:0] v,
      input logic               up,
      input logic               down
   );
      logic [SampleW-1:0] r;
      r = v;
      if (up && (v != '1)) begin
         r = v + 1'b1;
      end else if (down && (v != '0)) begin
         r = v - 1'b1;
      end
      return r;
   endfunction

   assign hold_target = hold_prev_ff ? hold_ref_ff : step.sample;
   assign temp_diff   = (step.sample >= real_temp_ff) ? step.sample - real_temp_ff
                                                      : real_temp_ff - step.sample;

   always_comb begin
      rank_in      = rank_ff + 1'b1;
      setpoint_in  = setpoint_ff;
      drive_in     = drive_ff;
      hold_ref_in  = hold_ref_ff;
      hold_prev_in = hold_prev_ff;
      current_in   = current_ff;
      real_temp_in = real_temp_ff;
      // flag clear and scan-init set act before the rank work
      cap_in       = cap_ff & ~step.clear_flags;
      ovc_in       = ovc_ff & ~step.clear_flags;
      scan_in      = scan_ff | step.set_scan_init;
      teq_in       = teq_ff;
      off_req      = 1'b0;
      win_update   = 1'b0;
      case (rank_ff)
         RANK_INNER_PD: begin
            if (step.power_hold_on) begin
               hold_ref_in = hold_target;
               drive_in    = step_toward(drive_ff, step.sample < hold_target,
                                         step.sample > hold_target);
            end
            hold_prev_in = step.power_hold_on;
         end
         RANK_EXT_PD: begin
            win_update = step.fire;
            if (step.stab_on) begin
               setpoint_in = step_toward(setpoint_ff,
                                         step.sample < cfg.capture_threshold,
                                         step.sample > cfg.capture_threshold);
            end
            if (step.in_stab_wait && (step.sample > cfg.capture_threshold)) begin
               cap_in = 1'b1;
            end
         end
         RANK_REAL_TEMP: begin
            real_temp_in = step.sample;
            if (current_ff > cfg.overcurrent_limit) begin
               off_req = 1'b1;
               ovc_in  = 1'b1;
            end
         end
         RANK_CURRENT: begin
            current_in = step.sample;
            if (step.sample > cfg.overcurrent_limit) begin
               off_req = 1'b1;
               ovc_in  = 1'b1;
            end
         end
         RANK_SET_TEMP: begin
            teq_in = temp_diff < cfg.temp_match_window;
            if (step.scan_init_settled && teq_in) begin
               scan_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= '0;
         setpoint_ff  <= RST_TEMP_SETPOINT_START;
         drive_ff     <= RST_LASER_DRIVE_START;
         hold_ref_ff  <= '0;
         hold_prev_ff <= 1'b0;
         current_ff   <= '0;
         real_temp_ff <= '0;
         cap_ff       <= 1'b0;
         teq_ff       <= 1'b0;
         scan_ff      <= 1'b0;
         ovc_ff       <= 1'b0;
      end else begin
         if (step.fire) begin
            rank_ff      <= rank_in;
            setpoint_ff  <= setpoint_in;
            drive_ff     <= drive_in;
            hold_ref_ff  <= hold_ref_in;
            hold_prev_ff <= hold_prev_in;
            current_ff   <= current_in;
            real_temp_ff <= real_temp_in;
            cap_ff       <= cap_in;
            teq_ff       <= teq_in;
            scan_ff      <= scan_in;
            ovc_ff       <= ovc_in;
         end
         if (preload.load_setpoint) begin
            setpoint_ff <= preload.data;
         end
         if (preload.load_drive) begin
            drive_ff <= preload.data;
         end
      end
   end

   always_comb begin
      result.sample_rank           = {1'b0, rank_ff} + 1'b1;
      result.temp_setpoint         = setpoint_in;
      result.temp_setpoint_changed = setpoint_in != setpoint_ff;
      result.laser_drive           = drive_in;
      result.capture_flag          = cap_in;
      result.temp_equal_flag       = teq_in;
      result.scan_init_flag        = scan_in;
      result.overcurrent_flag      = ovc_in;
      result.laser_off_request     = off_req;
   end

endmodule
